>>> design/mbet_pkg.sv
package mbet_pkg;

  // Number format and field widths
  localparam int FRAC_BITS = 28;
  localparam int ZW        = 32;
  localparam int CNT_W     = 16;
  localparam int N_W       = CNT_W + 1;
  localparam int RAD_W     = 31;
  localparam int PROD_W    = 2 * ZW;
  localparam int SQ_W      = PROD_W - 1 - FRAC_BITS;  // floor(z*z / 2^F), non-negative
  localparam int MAG_W     = SQ_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 1'b1;

  // Reset values; squared radius is capped at 4.0
  localparam logic [CNT_W-1:0] MAX_ITER_RST  = CNT_W'(255);
  localparam logic [RAD_W-1:0] RADIUS_SQ_CAP = RAD_W'(64'd4 << FRAC_BITS);

  typedef struct packed {
    logic signed [ZW-1:0] c_re;
    logic signed [ZW-1:0] c_im;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] escape_count;
    logic             in_set;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RR,
    S_II,
    S_RI,
    S_UPD,
    S_DONE
  } state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    OP_RR,
    OP_II,
    OP_RI
  } op_t;

  typedef struct packed {
    logic load;      // take a new point
    op_t  op;        // multiplier operands this cycle
    logic ld_re2;    // product holds zr*zr
    logic ld_im2;    // product holds zi*zi
    logic upd;       // product holds zr*zi, step z
    logic out_load;  // result into output register
  } ctl_t;

  typedef struct packed {
    logic escape;    // |z|^2 above radius
  } stat_t;

endpackage

>>> design/mbet_dp.sv
module mbet_dp (
  input  logic                        clk,
  input  mbet_pkg::in_item_t          item,
  input  mbet_pkg::ctl_t              ctl,
  input  logic [mbet_pkg::RAD_W-1:0]  radius_sq,
  output mbet_pkg::stat_t             stat
);
  import mbet_pkg::*;

  in_item_t            c_r;
  logic [ZW-1:0]       zr_r, zr_nxt;
  logic [ZW-1:0]       zi_r, zi_nxt;
  logic signed [ZW-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [SQ_W-1:0]     re2_r, im2_r;
  logic [MAG_W-1:0]    mag;

  // Shared multiplier operand select
  always_comb begin
    unique case (ctl.op)
      OP_RR: begin
        mul_a = $signed(zr_r);
        mul_b = $signed(zr_r);
      end
      OP_II: begin
        mul_a = $signed(zi_r);
        mul_b = $signed(zi_r);
      end
      OP_RI: begin
        mul_a = $signed(zr_r);
        mul_b = $signed(zi_r);
      end
      default: begin
        mul_a = $signed(zr_r);
        mul_b = $signed(zi_r);
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign mag         = MAG_W'(re2_r) + MAG_W'(im2_r);
  assign stat.escape = mag > MAG_W'(radius_sq);

  // z update wraps to 32 bits, so only the low bits of each term matter
  always_comb begin
    zr_nxt = zr_r;
    zi_nxt = zi_r;
    if (ctl.load) begin
      zr_nxt = item.c_re;
      zi_nxt = item.c_im;
    end else if (ctl.upd) begin
      zr_nxt = re2_r[ZW-1:0] - im2_r[ZW-1:0] + c_r.c_re;
      zi_nxt = prod_r[FRAC_BITS-1 +: ZW] + c_r.c_im;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c_r <= item;
    end
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    prod_r <= prod_nxt;
    if (ctl.ld_re2) begin
      re2_r <= prod_r[FRAC_BITS +: SQ_W];
    end
    if (ctl.ld_im2) begin
      im2_r <= prod_r[FRAC_BITS +: SQ_W];
    end
  end

endmodule

>>> design/mbet_ctrl.sv
module mbet_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic                        out_free,
  input  logic [mbet_pkg::CNT_W-1:0]  max_iter,
  input  mbet_pkg::stat_t             stat,
  output logic                        idle,
  output mbet_pkg::ctl_t              ctl,
  output mbet_pkg::out_item_t         res
);
  import mbet_pkg::*;

  state_t          state_r, state_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  out_item_t       res_r, res_nxt;
  logic            over;

  assign over = n_r > N_W'(max_iter);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) begin
        state_nxt = S_RR;
      end
      S_RR:    state_nxt = over ? S_DONE : S_II;
      S_II:    state_nxt = S_RI;
      S_RI:    state_nxt = S_UPD;
      S_UPD:   state_nxt = stat.escape ? S_DONE : S_RR;
      S_DONE:  if (out_free) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl = '0;
    ctl.op = OP_RR;
    unique case (state_r)
      S_IDLE: ctl.load = in_fire;
      S_RR:   ctl.op = OP_RR;
      S_II: begin
        ctl.op     = OP_II;
        ctl.ld_re2 = 1'b1;
      end
      S_RI: begin
        ctl.op     = OP_RI;
        ctl.ld_im2 = 1'b1;
      end
      S_UPD:  ctl.upd = ~stat.escape;
      S_DONE: ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

  assign idle = (state_r == S_IDLE);
  assign res  = res_r;

  always_comb begin
    n_nxt   = n_r;
    res_nxt = res_r;
    if (ctl.load) begin
      n_nxt = N_W'(1);
    end else if (state_r == S_RR && over) begin
      res_nxt.escape_count = '0;
      res_nxt.in_set       = 1'b1;
    end else if (state_r == S_UPD) begin
      if (stat.escape) begin
        res_nxt.escape_count = n_r[CNT_W-1:0];
        res_nxt.in_set       = 1'b0;
      end else begin
        n_nxt = n_r + N_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> design/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time unit. Takes one point c (two signed Q4.28 parts) per transfer on the
// in_ channel and returns one result per point on the out_ channel: the iteration count at
// which |z|^2 first exceeds the squared escape radius (starting at 1), or in_set with count 0
// when max_iter iterations pass without escape. Each iteration uses one shared 32x32 signed
// multiplier three times (zr*zr, zi*zi, zr*zi) and then one add/compare step; a point in the
// set also ends with a final count check. The reset max_iter is 255. One point is worked on
// at a time: in_ready is high only while the unit is idle. The result sits in an output
// register, so a new point may be taken while the previous result still waits for out_ready.
// Configuration (max_iter, escape_radius_sq) is written through the cfg_ port; the user must
// write it only while idle, which the block itself does not enforce. A squared radius above
// 4.0 acts as 4.0.
module mandelbrot_escape_time_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mbet_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mbet_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::RAD_W-1:0]      cfg_data
);
  import mbet_pkg::*;

  logic [CNT_W-1:0] max_iter_r, max_iter_nxt;
  logic [RAD_W-1:0] radius_sq_r, radius_sq_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;
  logic             idle;
  logic             in_fire;
  logic             out_free;
  ctl_t             ctl;
  stat_t            stat;
  out_item_t        res;

  assign in_ready = idle;
  assign in_fire  = in_valid & idle;
  // Output slot is free when empty or being drained this cycle
  assign out_free = ~out_valid_r | out_ready;

  // Config writes; the radius is stored already capped
  always_comb begin
    max_iter_nxt  = max_iter_r;
    radius_sq_nxt = radius_sq_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITER:  max_iter_nxt = cfg_data[CNT_W-1:0];
        CFG_RADIUS_SQ: radius_sq_nxt = (cfg_data > RADIUS_SQ_CAP) ? RADIUS_SQ_CAP : cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= MAX_ITER_RST;
      radius_sq_r <= RADIUS_SQ_CAP;
      out_valid_r <= 1'b0;
    end else begin
      max_iter_r  <= max_iter_nxt;
      radius_sq_r <= radius_sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (ctl.out_load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Sequencer: iteration count, state, result capture
  mbet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .max_iter (max_iter_r),
    .stat     (stat),
    .idle     (idle),
    .ctl      (ctl),
    .res      (res)
  );

  // z registers, shared multiplier, magnitude compare
  mbet_dp u_dp (
    .clk       (clk),
    .item      (in_data),
    .ctl       (ctl),
    .radius_sq (radius_sq_r),
    .stat      (stat)
  );

endmodule
